// File: src/fdrf_pkg.sv
`timescale 1ns / 1ps

package fdrf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIVE_W = 7;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_LOCAL = 2'd1,
    OP_CLEAN = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_BAD     = 3'd1,
    ST_DUP     = 3'd2,
    ST_LOCAL   = 3'd3,
    ST_CLEANED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_OWN_ADDR   = 3'd0,
    CFG_BCAST_ADDR = 3'd1,
    CFG_MEM_TIME   = 3'd2,
    CFG_RELAY_EN   = 3'd3,
    CFG_INVALID_ID = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] src;
    logic [31:0] pid;
    logic [31:0] stamp;
  } entry_t;

  // Request from the front end to the table engine.
  typedef struct packed {
    logic        start;
    op_t         op;
    logic        bad;
    logic [31:0] now;
    logic [15:0] src;
    logic [31:0] pid;
    logic        ack;
  } req_t;

  // Response from the table engine.
  typedef struct packed {
    logic             idle;
    logic             done;
    logic             dup;
    logic [CNT_W-1:0] count;
  } resp_t;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(TABLE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

// File: src/fdrf_table.sv
`timescale 1ns / 1ps

module fdrf_table (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    memory_time_ms,
  input  fdrf_pkg::req_t req,
  output fdrf_pkg::resp_t resp
);
  import fdrf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PUSH  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic rd_en, wr_en;

  logic [IDX_W-1:0] oldest, oldest_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic rd_pend, rd_pend_next;
  logic dup, dup_next;

  logic issue, hit, expired, full;
  logic [31:0] age;

  assign issue = (scan_cnt != count);
  assign hit = rd_pend && (rd_data.src == req.src) && (rd_data.pid == req.pid);
  assign age = req.now - rd_data.stamp;
  assign expired = age > memory_time_ms;
  assign full = (count == CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_next = state;
    oldest_next = oldest;
    tail_next = tail;
    count_next = count;
    scan_ptr_next = scan_ptr;
    scan_cnt_next = scan_cnt;
    rd_pend_next = rd_pend;
    dup_next = dup;
    rd_en = 1'b0;
    rd_addr = scan_ptr;
    wr_en = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          rd_pend_next = 1'b0;
          scan_ptr_next = oldest;
          scan_cnt_next = '0;
          dup_next = 1'b0;
          case (req.op)
            OP_RECV: state_next = req.bad ? S_FIN : S_SCAN;
            OP_LOCAL: state_next = S_PUSH;
            default: state_next = S_SWEEP;
          endcase
        end
      end
      S_SCAN: begin
        // One stored record is read per cycle; it is compared in the cycle after its read.
        if (hit) begin
          dup_next = 1'b1;
          state_next = S_FIN;
        end else if (!issue && !rd_pend) begin
          state_next = S_PUSH;
        end else begin
          rd_en = issue;
          if (issue) begin
            scan_ptr_next = slot_inc(scan_ptr);
            scan_cnt_next = scan_cnt + 1'b1;
          end
          rd_pend_next = issue;
        end
      end
      S_PUSH: begin
        // When full, the tail slot is the oldest one, so it gets overwritten.
        wr_en = 1'b1;
        tail_next = slot_inc(tail);
        if (full) begin
          oldest_next = slot_inc(oldest);
        end else begin
          count_next = count + 1'b1;
        end
        state_next = S_FIN;
      end
      S_SWEEP: begin
        if (rd_pend) begin
          rd_pend_next = 1'b0;
          if (expired) begin
            oldest_next = slot_inc(oldest);
            count_next = count - 1'b1;
          end else begin
            state_next = S_FIN;
          end
        end else if (count == '0) begin
          state_next = S_FIN;
        end else begin
          rd_en = 1'b1;
          rd_addr = oldest;
          rd_pend_next = 1'b1;
        end
      end
      S_FIN: begin
        if (req.ack) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oldest <= '0;
      tail <= '0;
      count <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      oldest <= oldest_next;
      tail <= tail_next;
      count <= count_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    scan_cnt <= scan_cnt_next;
    dup <= dup_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= '{src: req.src, pid: req.pid, stamp: req.now};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign resp.idle = (state == S_IDLE);
  assign resp.done = (state == S_FIN);
  assign resp.dup = dup;
  assign resp.count = count;

endmodule

// File: src/flood_dedup_rebroadcast_filter_unit.sv
`timescale 1ns / 1ps

// Duplicate filter and rebroadcast decision for a flooding mesh node. Each request
// (received header, local send or cleanup) is worked on alone; the block drops
// in_ready until the engine is free again. A received header is compared against
// the stored records one per cycle through the single read port of the record
// memory, which holds up to 64 records. A cleanup reads records from the oldest
// on and drops each expired one until it meets one still in its time window or
// the table is empty. A finished result sits in the output register while the
// next request is taken; opcode 3 is accepted and gives no result.

module flood_dedup_rebroadcast_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] now_ms,
  input  logic [15:0] source_id,
  input  logic [31:0] packet_id,
  input  logic [15:0] dest_id,
  input  logic [7:0]  hop_count,
  input  logic [7:0]  hop_limit,
  input  logic        checksum_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        relay,
  output logic        hop_exhausted,
  output logic [7:0]  next_hop_count,
  output logic [6:0]  live_records
);
  import fdrf_pkg::*;

  logic [15:0] own_address, broadcast_address;
  logic [31:0] memory_time_ms, invalid_packet_id;
  logic relay_enable;

  op_t op;
  logic [31:0] now_q, pid_q;
  logic [15:0] src_q, dst_q;
  logic [7:0] hops_q, limit_q;
  logic ck_q;
  logic start;

  req_t req;
  resp_t resp;

  logic accept, ack, load;
  logic to_us, from_us, exhausted, is_new;
  logic [2:0] status_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 16'd1;
      broadcast_address <= 16'hFFFF;
      memory_time_ms <= 32'd300000;
      relay_enable <= 1'b0;
      invalid_packet_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_ADDR: own_address <= cfg_data[15:0];
        CFG_BCAST_ADDR: broadcast_address <= cfg_data[15:0];
        CFG_MEM_TIME: memory_time_ms <= cfg_data;
        CFG_RELAY_EN: relay_enable <= cfg_data[0];
        CFG_INVALID_ID: invalid_packet_id <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = resp.idle && !start;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= accept && (op_t'(opcode) != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_t'(opcode);
      now_q <= now_ms;
      src_q <= source_id;
      pid_q <= packet_id;
      dst_q <= dest_id;
      hops_q <= hop_count;
      limit_q <= hop_limit;
      ck_q <= checksum_ok;
    end
  end

  assign ack = !out_valid || out_ready;

  assign req.start = start;
  assign req.op = op;
  assign req.bad = !ck_q;
  assign req.now = now_q;
  assign req.src = src_q;
  assign req.pid = pid_q;
  assign req.ack = ack;

  fdrf_table u_table (
    .clk            (clk),
    .rst            (rst),
    .memory_time_ms (memory_time_ms),
    .req            (req),
    .resp           (resp)
  );

  assign load = resp.done && ack;
  assign to_us = (dst_q == own_address) || (dst_q == broadcast_address);
  assign from_us = (src_q == own_address);
  assign exhausted = (hops_q >= limit_q);
  assign is_new = (op == OP_RECV) && ck_q && !resp.dup;

  always_comb begin
    case (op)
      OP_RECV: begin
        if (!ck_q) begin
          status_next = ST_BAD;
        end else if (resp.dup) begin
          status_next = ST_DUP;
        end else begin
          status_next = ST_NEW;
        end
      end
      OP_LOCAL: status_next = ST_LOCAL;
      default: status_next = ST_CLEANED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      relay <= is_new && !to_us && !from_us && !exhausted &&
               (pid_q != invalid_packet_id) && relay_enable;
      hop_exhausted <= is_new && exhausted;
      next_hop_count <= !is_new ? 8'd0 : (hops_q == 8'hFF) ? 8'hFF : hops_q + 8'd1;
      live_records <= LIVE_W'(resp.count);
    end
  end

endmodule

// File: src/fdrf_checker.sv
`timescale 1ns / 1ps

module fdrf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        relay,
  input logic        hop_exhausted,
  input logic [7:0]  next_hop_count,
  input logic [6:0]  live_records
);
  import fdrf_pkg::*;

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(live_records))
    else $error("result changed while stalled");

  // A request that does table work drops in_ready in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode != OP_NONE) |=> !in_ready)
    else $error("ready stayed high after a request");

  a_relay_new_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && relay |-> (status == ST_NEW) && !hop_exhausted)
    else $error("relay on a result that is not a new header");

  a_hop_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_NEW) |-> !hop_exhausted && (next_hop_count == 8'd0))
    else $error("hop fields set on a result that is not a new header");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (live_records <= LIVE_W'(TABLE_DEPTH)))
    else $error("live record count above table depth");

endmodule

bind flood_dedup_rebroadcast_filter_unit fdrf_checker u_fdrf_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fdrf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 150;
  localparam int CALM_FIRST = 250;
  localparam int CALM_LAST = 380;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    logic [15:0] src;
    logic [31:0] pid;
    logic [15:0] dst;
    logic [7:0]  hops;
    logic [7:0]  limit;
    logic        ck;
  } pkt_req_t;

  typedef struct {
    status_t    status;
    logic       relay;
    logic       exhausted;
    logic [7:0] next_hops;
    logic [6:0] live;
  } verdict_t;

  typedef enum logic [1:0] {
    JOB_PKT,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t   kind;
    pkt_req_t    pkt;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_val;
  } job_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] now_ms = '0;
  logic [15:0] source_id = '0;
  logic [31:0] packet_id = '0;
  logic [15:0] dest_id = '0;
  logic [7:0]  hop_count = '0;
  logic [7:0]  hop_limit = '0;
  logic        checksum_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        relay;
  logic        hop_exhausted;
  logic [7:0]  next_hop_count;
  logic [6:0]  live_records;

  // Stimulus plan and outstanding verdicts.
  job_t        plan_q[$];
  verdict_t    verdict_q[$];
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned settle_cnt = 0;
  logic        in_took = 1'b0;
  logic        cfg_took = 1'b0;

  // Predicted settings and record ring.
  logic [15:0] my_addr = 16'd1;
  logic [15:0] all_addr = 16'hFFFF;
  logic [31:0] hold_ms = 32'd300000;
  logic        relay_on = 1'b0;
  logic [31:0] void_pid = 32'd0;
  logic [15:0] log_src[TABLE_DEPTH];
  logic [31:0] log_pid[TABLE_DEPTH];
  logic [31:0] log_stamp[TABLE_DEPTH];
  int unsigned log_head = 0;
  int unsigned log_held = 0;

  // Generator state: a running clock and recently sent (source, id) pairs.
  logic [31:0] clock_ms = '0;
  logic [15:0] hist_src[$];
  logic [31:0] hist_pid[$];

  flood_dedup_rebroadcast_filter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .source_id     (source_id),
    .packet_id     (packet_id),
    .dest_id       (dest_id),
    .hop_count     (hop_count),
    .hop_limit     (hop_limit),
    .checksum_ok   (checksum_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .relay         (relay),
    .hop_exhausted (hop_exhausted),
    .next_hop_count(next_hop_count),
    .live_records  (live_records)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void log_record(input logic [15:0] src, input logic [31:0] pid,
                                     input logic [31:0] now);
    int unsigned slot;
    if (log_held >= TABLE_DEPTH) begin
      log_head = (log_head + 1) % TABLE_DEPTH;
      log_held = TABLE_DEPTH - 1;
    end
    slot = (log_head + log_held) % TABLE_DEPTH;
    log_src[slot] = src;
    log_pid[slot] = pid;
    log_stamp[slot] = now;
    log_held++;
  endfunction

  function automatic void screen_packet(input pkt_req_t p, output logic yields,
                                        output verdict_t v);
    logic        dup;
    int unsigned i;
    int unsigned slot;
    yields = 1'b1;
    dup = 1'b0;
    v = '{ST_NEW, 1'b0, 1'b0, 8'd0, 7'd0};
    case (p.op)
      OP_RECV: begin
        if (!p.ck) begin
          v.status = ST_BAD;
        end else begin
          for (i = 0; i < log_held; i++) begin
            slot = (log_head + i) % TABLE_DEPTH;
            if (log_src[slot] == p.src && log_pid[slot] == p.pid) dup = 1'b1;
          end
          if (dup) begin
            v.status = ST_DUP;
          end else begin
            log_record(p.src, p.pid, p.now);
            v.exhausted = (p.hops >= p.limit);
            v.next_hops = (p.hops == 8'hFF) ? 8'hFF : p.hops + 8'd1;
            v.relay = p.dst != my_addr && p.dst != all_addr && p.src != my_addr &&
                      !v.exhausted && p.pid != void_pid && relay_on;
          end
        end
      end
      OP_LOCAL: begin
        log_record(p.src, p.pid, p.now);
        v.status = ST_LOCAL;
      end
      OP_CLEAN: begin
        v.status = ST_CLEANED;
        // Ages are taken modulo 2^32 so that a wrapped clock still works.
        while (log_held > 0 && (p.now - log_stamp[log_head]) > hold_ms) begin
          log_head = (log_head + 1) % TABLE_DEPTH;
          log_held--;
        end
      end
      default: yields = 1'b0;
    endcase
    v.live = 7'(log_held);
  endfunction

  function automatic void queue_pkt(op_t op, logic [31:0] now, logic [15:0] src,
                                    logic [31:0] pid, logic [15:0] dst, logic [7:0] hops,
                                    logic [7:0] limit, logic ck);
    job_t j;
    j.kind = JOB_PKT;
    j.pkt = '{op, now, src, pid, dst, hops, limit, ck};
    j.reg_idx = CFG_OWN_ADDR;
    j.reg_val = '0;
    plan_q = {plan_q, j};
  endfunction

  function automatic void queue_cfg(cfg_idx_t idx, logic [31:0] val);
    job_t j;
    j.kind = JOB_CFG;
    j.pkt = '{OP_NONE, '0, '0, '0, '0, '0, '0, 1'b0};
    j.reg_idx = idx;
    j.reg_val = val;
    plan_q = {plan_q, j};
  endfunction

  function automatic void queue_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.pkt = '{OP_NONE, '0, '0, '0, '0, '0, '0, 1'b0};
    j.reg_idx = CFG_OWN_ADDR;
    j.reg_val = '0;
    plan_q = {plan_q, j};
  endfunction

  // Settings only change once the block has gone quiet.
  function automatic void queue_settings(logic [15:0] own, logic [15:0] bcast,
                                         logic [31:0] mem, logic en, logic [31:0] nix);
    queue_drain();
    queue_cfg(CFG_OWN_ADDR, {16'd0, own});
    queue_cfg(CFG_BCAST_ADDR, {16'd0, bcast});
    queue_cfg(CFG_MEM_TIME, mem);
    queue_cfg(CFG_RELAY_EN, {31'd0, en});
    queue_cfg(CFG_INVALID_ID, nix);
  endfunction

  // Mostly well-formed traffic from a small set of nodes, with repeats of
  // recent packets, plus bad checksums, odd addresses and ignored opcodes.
  function automatic void queue_random(int unsigned n, logic [15:0] own,
                                       logic [15:0] bcast, logic [31:0] nix);
    pkt_req_t    p;
    int unsigned done_n;
    int unsigned roll;
    int unsigned k;
    done_n = 0;
    while (done_n < n) begin
      roll = $urandom_range(99);
      if (roll < 72) p.op = OP_RECV;
      else if (roll < 86) p.op = OP_LOCAL;
      else if (roll < 96) p.op = OP_CLEAN;
      else p.op = OP_NONE;
      if ($urandom_range(39) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(400);
      p.now = clock_ms;
      roll = $urandom_range(99);
      if (roll < 15) p.src = own;
      else if (roll < 60) p.src = 16'($urandom_range(1, 12));
      else p.src = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 50) p.pid = $urandom_range(40);
      else if (roll < 60) p.pid = nix;
      else p.pid = $urandom;
      if (hist_src.size() > 0 && $urandom_range(3) == 0) begin
        k = $urandom_range(hist_src.size() - 1);
        p.src = hist_src[k];
        p.pid = hist_pid[k];
      end else begin
        hist_src = {hist_src, p.src};
        hist_pid = {hist_pid, p.pid};
        if (hist_src.size() > 120) begin
          hist_src.delete(0);
          hist_pid.delete(0);
        end
      end
      roll = $urandom_range(99);
      if (roll < 20) p.dst = own;
      else if (roll < 40) p.dst = bcast;
      else if (roll < 70) p.dst = 16'($urandom_range(12));
      else p.dst = 16'($urandom);
      p.hops = ($urandom_range(1) == 1) ? 8'($urandom_range(8)) : 8'($urandom);
      p.limit = ($urandom_range(1) == 1) ? 8'($urandom_range(2, 9)) : 8'($urandom);
      p.ck = ($urandom_range(9) != 0);
      queue_pkt(p.op, p.now, p.src, p.pid, p.dst, p.hops, p.limit, p.ck);
      if (p.op != OP_NONE) done_n++;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Driver: loads the next request at the falling edge once the previous one
  // has been taken.
  always @(negedge clk) begin
    job_t j;
    logic pkt_v;
    logic cfg_v;
    logic calm;
    pkt_v = in_valid && !in_took;
    cfg_v = cfg_valid && !cfg_took;
    calm = (sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST);
    if (!rst && !pkt_v && !cfg_v && plan_q.size() > 0) begin
      j = plan_q[0];
      case (j.kind)
        JOB_DRAIN: begin
          if (verdict_q.size() != 0) begin
            settle_cnt = 0;
          end else if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            plan_q.delete(0);
          end
        end
        JOB_CFG: begin
          cfg_v = 1'b1;
          cfg_index <= j.reg_idx;
          cfg_data <= j.reg_val;
          plan_q.delete(0);
        end
        default: begin
          if (calm || $urandom_range(99) >= 37) begin
            pkt_v = 1'b1;
            opcode <= j.pkt.op;
            now_ms <= j.pkt.now;
            source_id <= j.pkt.src;
            packet_id <= j.pkt.pid;
            dest_id <= j.pkt.dst;
            hop_count <= j.pkt.hops;
            hop_limit <= j.pkt.limit;
            checksum_ok <= j.pkt.ck;
            plan_q.delete(0);
            sent_cnt++;
          end
        end
      endcase
    end
    in_valid <= pkt_v;
    cfg_valid <= cfg_v;
    out_ready <= calm || ($urandom_range(99) >= 37);
  end

  // Monitor: checks results, then applies accepted writes and requests to the
  // predicted state.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t fresh;
    pkt_req_t got_pkt;
    logic     yields;
    cycle_cnt++;
    in_took = !rst && in_valid && in_ready;
    cfg_took = !rst && cfg_valid && cfg_ready;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $error("unexpected result: status %0d live_records %0d", status, live_records);
      end else begin
        want = verdict_q.pop_front();
        check_field("status", want.status, status);
        check_field("relay", want.relay, relay);
        check_field("hop_exhausted", want.exhausted, hop_exhausted);
        check_field("next_hop_count", want.next_hops, next_hop_count);
        check_field("live_records", want.live, live_records);
      end
    end
    if (cfg_took) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_ADDR:   my_addr = cfg_data[15:0];
        CFG_BCAST_ADDR: all_addr = cfg_data[15:0];
        CFG_MEM_TIME:   hold_ms = cfg_data;
        CFG_RELAY_EN:   relay_on = cfg_data[0];
        CFG_INVALID_ID: void_pid = cfg_data;
        default: ;
      endcase
    end
    if (in_took) begin
      got_pkt = '{op_t'(opcode), now_ms, source_id, packet_id, dest_id, hop_count,
                  hop_limit, checksum_ok};
      screen_packet(got_pkt, yields, fresh);
      if (yields) verdict_q = {verdict_q, fresh};
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    queue_settings(16'd5, 16'hFFFF, 32'd1000, 1'b1, 32'd0);
    queue_pkt(OP_RECV, 32'd100, 16'd7, 32'd100, 16'd9, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd110, 16'd7, 32'd100, 16'd9, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd120, 16'd7, 32'd101, 16'd9, 8'd0, 8'd3, 1'b0);
    queue_pkt(OP_RECV, 32'd130, 16'd8, 32'd1, 16'd5, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd140, 16'd8, 32'd2, 16'hFFFF, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd150, 16'd5, 32'd3, 16'd9, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd160, 16'd8, 32'd4, 16'd9, 8'd3, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd170, 16'd8, 32'd5, 16'd9, 8'd255, 8'd255, 1'b1);
    queue_pkt(OP_RECV, 32'd180, 16'd8, 32'd6, 16'd9, 8'd254, 8'd255, 1'b1);
    queue_pkt(OP_RECV, 32'd190, 16'd8, 32'd0, 16'd9, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'd200, 16'd8, 32'd7, 16'd9, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_LOCAL, 32'd210, 16'd5, 32'd200, 16'd0, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_RECV, 32'd220, 16'd5, 32'd200, 16'd9, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_NONE, 32'd230, 16'd9, 32'd9, 16'd9, 8'd0, 8'd3, 1'b1);
    queue_pkt(OP_RECV, 32'hFFFFFF00, 16'hFFFF, 32'hFFFFFFFF, 16'd0, 8'd0, 8'd255, 1'b1);
    // Wrapped clock: the newest record is only 512 ms old here.
    queue_pkt(OP_CLEAN, 32'h00000100, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    // Partial sweep that stops at the first record still inside the window.
    queue_pkt(OP_CLEAN, 32'd1135, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_CLEAN, 32'hFFFF0000, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_CLEAN, 32'd0, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_LOCAL, 32'd0, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_RECV, 32'd5, 16'd0, 32'd0, 16'hFFFF, 8'd0, 8'd3, 1'b1);
    // A record exactly at the age limit survives; one millisecond later it goes.
    queue_pkt(OP_CLEAN, 32'd1000, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);
    queue_pkt(OP_CLEAN, 32'd1001, 16'd0, 32'd0, 16'd0, 8'd0, 8'd0, 1'b1);

    queue_settings(16'd0, 16'd0, 32'd0, 1'b1, 32'hFFFFFFFF);
    queue_random(150, 16'd0, 16'd0, 32'hFFFFFFFF);
    queue_settings(16'hFFFF, 16'hFFFE, 32'hFFFFFFFF, 1'b0, 32'd17);
    queue_random(150, 16'hFFFF, 16'hFFFE, 32'd17);
    queue_settings(16'd3, 16'hFFFF, 32'd3000, 1'b1, 32'd0);
    queue_random(150, 16'd3, 16'hFFFF, 32'd0);
    queue_drain();
    queue_random(150, 16'd3, 16'hFFFF, 32'd0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (plan_q.size() != 0 || in_valid || cfg_valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
